@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fpr_pkg.sv @@
`default_nettype none

package fpr_pkg;

    typedef enum logic [3:0] {
        PH_SYNC   = 4'd0,
        PH_SIZE   = 4'd1,
        PH_NSIZE  = 4'd2,
        PH_DEST   = 4'd3,
        PH_ORIG   = 4'd4,
        PH_CMD    = 4'd5,
        PH_DATA   = 4'd6,
        PH_CHK_HI = 4'd7,
        PH_CHK_LO = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_FAIL    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_LOCAL_ADDRESS = 2'd0,
        REG_SYNC_VALUE    = 2'd1,
        REG_CHECK_WORD    = 2'd2
    } reg_index_t;

    localparam logic [7:0]  LOCAL_ADDRESS_RESET = 8'd0;
    localparam logic [7:0]  SYNC_VALUE_RESET    = 8'd170;
    localparam logic [15:0] CHECK_WORD_RESET    = 16'h1234;

    typedef struct packed {
        logic [7:0]  local_address;
        logic [7:0]  sync_value;
        logic [15:0] check_word;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] sender_address;
        logic [7:0] command_code;
        logic [7:0] payload_size;
    } res_t;

    typedef struct packed {
        phase_t phase;
        logic   ignore_frame;
    } parse_status_t;

endpackage

`default_nettype wire

@@ rtl/core/fpr_cfg_regs.sv @@
`default_nettype none

module fpr_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output fpr_pkg::cfg_t    cfg
);
    import fpr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_address <= LOCAL_ADDRESS_RESET;
            cfg_reg.sync_value    <= SYNC_VALUE_RESET;
            cfg_reg.check_word    <= CHECK_WORD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOCAL_ADDRESS: cfg_reg.local_address <= cfg_data[7:0];
                REG_SYNC_VALUE:    cfg_reg.sync_value    <= cfg_data[7:0];
                REG_CHECK_WORD:    cfg_reg.check_word    <= cfg_data;
                default:           ; // no register at this index
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/fpr_parser.sv @@
`default_nettype none

module fpr_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fpr_pkg::cfg_t  cfg,
    input  wire logic           fire,
    input  wire logic [7:0]     rx_byte,
    output logic                res_valid,
    output fpr_pkg::res_t       res,
    output fpr_pkg::parse_status_t status
);
    import fpr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] sender_reg, sender_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] count_reg, count_next;
    logic       ignore_reg, ignore_next;
    logic       chk_hi_reg, chk_hi_next;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC;
            size_reg    <= 8'd0;
            sender_reg  <= 8'd0;
            command_reg <= 8'd0;
            count_reg   <= 8'd0;
            ignore_reg  <= 1'b0;
            chk_hi_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            size_reg    <= size_next;
            sender_reg  <= sender_next;
            command_reg <= command_next;
            count_reg   <= count_next;
            ignore_reg  <= ignore_next;
            chk_hi_reg  <= chk_hi_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        size_next    = size_reg;
        sender_next  = sender_reg;
        command_next = command_reg;
        count_next   = count_reg;
        ignore_next  = ignore_reg;
        chk_hi_next  = chk_hi_reg;
        res_valid    = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.payload_index  = 8'd0;
        res.sender_address = sender_reg;
        res.command_code   = command_reg;
        res.payload_size   = size_reg;

        unique case (phase_reg)
            PH_SYNC:
            begin
                if (rx_byte == cfg.sync_value)
                begin
                    count_next   = 8'd0;
                    chk_hi_next  = 1'b0;
                    ignore_next  = 1'b0;
                    size_next    = 8'd0;
                    sender_next  = 8'd0;
                    command_next = 8'd0;
                    phase_next   = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                size_next  = rx_byte;
                phase_next = PH_NSIZE;
            end
            PH_NSIZE:
            begin
                if ((8'd0 - size_reg) != rx_byte)
                begin
                    count_next  = 8'd0;
                    chk_hi_next = 1'b0;
                    ignore_next = 1'b1;
                end
                phase_next = PH_DEST;
            end
            PH_DEST:
            begin
                if (!(rx_byte == cfg.local_address && !ignore_reg))
                begin
                    count_next  = 8'd0;
                    chk_hi_next = 1'b0;
                    ignore_next = 1'b1;
                end
                phase_next = PH_ORIG;
            end
            PH_ORIG:
            begin
                if (!ignore_reg)
                    sender_next = rx_byte;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                if (!ignore_reg)
                    command_next = rx_byte;
                phase_next = (size_reg != 8'd0) ? PH_DATA : PH_CHK_HI;
            end
            PH_DATA:
            begin
                if (!ignore_reg)
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = count_reg;
                end
                count_next = count_inc;
                if (count_inc == size_reg)
                    phase_next = PH_CHK_HI;
            end
            PH_CHK_HI:
            begin
                if (!ignore_reg)
                    chk_hi_next = (rx_byte == cfg.check_word[15:8]);
                phase_next = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                if (!ignore_reg)
                begin
                    res_valid = 1'b1;
                    res.kind  = (chk_hi_reg && rx_byte == cfg.check_word[7:0])
                                ? KIND_ACCEPT : KIND_FAIL;
                end
                count_next  = 8'd0;
                chk_hi_next = 1'b0;
                ignore_next = 1'b1;
                phase_next  = PH_SYNC;
            end
            default:
            begin
                // unused phase code: drop the byte and resync
                count_next  = 8'd0;
                chk_hi_next = 1'b0;
                ignore_next = 1'b1;
                phase_next  = PH_SYNC;
            end
        endcase
    end

    assign status.phase        = phase_reg;
    assign status.ignore_frame = ignore_reg;

endmodule

`default_nettype wire

@@ rtl/core/fpr_out_buf.sv @@
`default_nettype none

module fpr_out_buf (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire fpr_pkg::res_t push_data,
    output logic          full,
    output logic          out_valid,
    input  wire logic     out_stall,
    output fpr_pkg::res_t out_data
);
    import fpr_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no push while the skid holds an item
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_take)
                out_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/framed_packet_receiver_top.sv @@
// a result item is registered: the byte that causes it is written into the main output entry,
// or the skid entry while the main one waits; one received byte per cycle while the skid entry
// is free; the two-entry output register (main plus skid) lets bytes flow while a result waits;
// reset: rst_n is asynchronous and active low; phase returns to sync hunt, frame fields clear
// and the registers take their reset values
`default_nettype none

`include "assert_macros.svh"

module framed_packet_receiver_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // received byte channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [7:0]       payload_index,
    output logic [7:0]       sender_address,
    output logic [7:0]       command_code,
    output logic [7:0]       payload_size,
    // register write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import fpr_pkg::*;

    cfg_t          cfg;
    logic          fire;
    logic          res_valid;
    res_t          res;
    parse_status_t status;
    logic          buf_full;
    logic          push;
    res_t          out_data;

    // register writes are always taken; the user must write only while idle, not enforced
    assign cfg_ready = 1'b1;

    fpr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a byte is taken whenever the skid entry is free, so a result always has room
    assign in_stall = buf_full;
    assign fire     = in_valid && !in_stall;
    assign push     = fire && res_valid;

    // frame state machine: one byte per accepted item
    fpr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    // result register with skid entry
    fpr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign payload_byte   = out_data.payload_byte;
    assign payload_index  = out_data.payload_index;
    assign sender_address = out_data.sender_address;
    assign command_code   = out_data.command_code;
    assign payload_size   = out_data.payload_size;

    // the skid entry only fills behind a waiting main entry
    `ASSERT_IMPLIES(a_skid_behind_main, in_stall, out_valid, "skid full with empty output")
    // payload items come only from the payload phase of a kept frame
    `ASSERT_IMPLIES(a_payload_from_kept, push && res.kind == KIND_PAYLOAD,
        status.phase == PH_DATA && !status.ignore_frame, "payload item outside kept payload")
    // a verdict ends the frame and sends the block back to sync hunt
    `ASSERT_NEXT(a_verdict_resync, push && res.kind != KIND_PAYLOAD,
        status.phase == PH_SYNC, "no resync after verdict")

endmodule

`default_nettype wire

@@ verif/framed_packet_receiver_top_tb.sv @@
`default_nettype none

module framed_packet_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpr_pkg::*;

    // receiver stall styles, chosen per phase
    typedef enum int {
        STALL_NONE,
        STALL_SOME,
        STALL_PATTERN,
        STALL_HEAVY
    } stall_style_t;

    localparam int unsigned LONG_HOLD_CYCLES = 120;
    localparam int unsigned DRAIN_CYCLES     = 4;
    localparam int unsigned MAX_PRINTED      = 100;

    // dut ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  sender_address;
    logic [7:0]  command_code;
    logic [7:0]  payload_size;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_LOCAL_ADDRESS;
    logic [15:0] cfg_data = 16'h0000;

    // register shadows used by the deframer prediction and the frame builder
    logic [7:0]  own_address = LOCAL_ADDRESS_RESET;
    logic [7:0]  start_marker = SYNC_VALUE_RESET;
    logic [15:0] expected_check = CHECK_WORD_RESET;

    // predicted deframer state
    phase_t      rx_phase = PH_SYNC;
    logic [7:0]  hdr_size = 8'h00;
    logic [7:0]  hdr_sender = 8'h00;
    logic [7:0]  hdr_command = 8'h00;
    logic [7:0]  data_count = 8'h00;
    logic        frame_ignored = 1'b0;
    logic        check_hi_match = 1'b0;

    // bytes still to be sent, and results still to arrive
    logic [7:0]  rx_bytes_pending[$];
    res_t        expected_results[$];
    res_t        oldest;

    // sender and receiver behavior, set by the sequencing block
    logic         sender_bursty = 1'b0;
    logic         sender_hold = 1'b0;
    stall_style_t stall_style = STALL_NONE;
    logic [7:0]   stall_pattern = 8'h00;
    int unsigned  hold_requests = 0;

    int unsigned  burst_left = 0;
    int unsigned  gap_left = 0;
    int unsigned  hold_left = 0;
    int unsigned  holds_served = 0;
    int unsigned  stall_tick = 0;

    // bookkeeping
    int unsigned  error_count = 0;
    int unsigned  bytes_accepted = 0;
    int unsigned  frame_bytes_queued = 0;
    int unsigned  frames_queued = 0;
    int unsigned  settings_used = 1;
    int unsigned  payload_seen = 0;
    int unsigned  accepted_seen = 0;
    int unsigned  failed_seen = 0;

    framed_packet_receiver_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .sender_address (sender_address),
        .command_code   (command_code),
        .payload_size   (payload_size),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("timeout: %0d results still outstanding", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // walk one received byte through the frame and queue the result it causes
    function automatic void deframe_byte(logic [7:0] b);
        res_t r;
        r = '0;
        case (rx_phase)
            PH_SYNC:
            begin
                // anything other than the sync value is dropped while hunting
                if (b == start_marker)
                begin
                    data_count = 8'h00;
                    check_hi_match = 1'b0;
                    frame_ignored = 1'b0;
                    hdr_size = 8'h00;
                    hdr_sender = 8'h00;
                    hdr_command = 8'h00;
                    rx_phase = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                hdr_size = b;
                rx_phase = PH_NSIZE;
            end
            PH_NSIZE:
            begin
                // size plus its complement must wrap to zero
                if (8'(b + hdr_size) != 8'h00)
                begin
                    data_count = 8'h00;
                    check_hi_match = 1'b0;
                    frame_ignored = 1'b1;
                end
                rx_phase = PH_DEST;
            end
            PH_DEST:
            begin
                if (b != own_address || frame_ignored)
                begin
                    data_count = 8'h00;
                    check_hi_match = 1'b0;
                    frame_ignored = 1'b1;
                end
                rx_phase = PH_ORIG;
            end
            PH_ORIG:
            begin
                if (!frame_ignored)
                    hdr_sender = b;
                rx_phase = PH_CMD;
            end
            PH_CMD:
            begin
                if (!frame_ignored)
                    hdr_command = b;
                rx_phase = (hdr_size != 8'h00) ? PH_DATA : PH_CHK_HI;
            end
            PH_DATA:
            begin
                // ignored frames only count their payload
                if (!frame_ignored)
                begin
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.payload_index = data_count;
                    r.sender_address = hdr_sender;
                    r.command_code = hdr_command;
                    r.payload_size = hdr_size;
                    expected_results.push_back(r);
                end
                data_count = data_count + 8'd1;
                if (data_count == hdr_size)
                    rx_phase = PH_CHK_HI;
            end
            PH_CHK_HI:
            begin
                if (!frame_ignored)
                    check_hi_match = (b == expected_check[15:8]);
                rx_phase = PH_CHK_LO;
            end
            PH_CHK_LO:
            begin
                // verdict for kept frames only
                if (!frame_ignored)
                begin
                    r.kind = (check_hi_match && b == expected_check[7:0]) ?
                             KIND_ACCEPT : KIND_FAIL;
                    r.sender_address = hdr_sender;
                    r.command_code = hdr_command;
                    r.payload_size = hdr_size;
                    expected_results.push_back(r);
                end
                data_count = 8'h00;
                check_hi_match = 1'b0;
                frame_ignored = 1'b1;
                rx_phase = PH_SYNC;
            end
            default:
            begin
                data_count = 8'h00;
                check_hi_match = 1'b0;
                frame_ignored = 1'b1;
                rx_phase = PH_SYNC;
            end
        endcase
    endfunction

    // byte driver: bursts of items with random gaps when bursty, holds the item while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'h00;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            // an item moves on this edge: predict what it causes
            if (in_valid && !in_stall)
            begin
                deframe_byte(rx_byte);
                bytes_accepted++;
            end
            // only free to change the payload when nothing is held by a stall
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (rx_bytes_pending.size() != 0 && !sender_hold)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_bytes_pending.pop_front();
                    if (burst_left != 0)
                        burst_left--;
                    else if (sender_bursty)
                    begin
                        burst_left = $urandom_range(0, 11);
                        gap_left = $urandom_range(0, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: long holds on request, otherwise the style of the phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            stall_tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (holds_served != hold_requests)
            begin
                // long hold so the skid fills and the input backs up
                holds_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_style)
                    STALL_SOME:    out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PATTERN: out_stall <= stall_pattern[3'(stall_tick)];
                    STALL_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
                    default:       out_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want_v);
        if (got !== want_v)
            report_error($sformatf("%s: got %02h, want %02h", name, got, want_v));
    endtask

    // result monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_error($sformatf("result with nothing expected: kind %0d byte %02h",
                                       kind, payload_byte));
            else
            begin
                oldest = expected_results.pop_front();
                check_field("kind", {6'd0, kind}, {6'd0, oldest.kind});
                check_field("payload_byte", payload_byte, oldest.payload_byte);
                check_field("payload_index", payload_index, oldest.payload_index);
                check_field("sender_address", sender_address, oldest.sender_address);
                check_field("command_code", command_code, oldest.command_code);
                check_field("payload_size", payload_size, oldest.payload_size);
            end
            case (kind)
                KIND_PAYLOAD: payload_seen++;
                KIND_ACCEPT:  accepted_seen++;
                default:      failed_seen++;
            endcase
        end
    end

    // register write, only issued while the block has nothing in flight
    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LOCAL_ADDRESS: own_address = value[7:0];
            REG_SYNC_VALUE:    start_marker = value[7:0];
            default:           expected_check = value;
        endcase
    endtask

    function automatic logic [7:0] corrupt(logic [7:0] v);
        return v ^ 8'($urandom_range(1, 255));
    endfunction

    // queue one frame; keep cuts it short, marked fills the payload with edge values
    task automatic queue_frame(logic [7:0] size, logic [7:0] size_neg, logic [7:0] dest,
                               logic [15:0] check, int unsigned keep, bit marked);
        logic [7:0] fb[$];
        logic [7:0] pb;
        fb.push_back(start_marker);
        fb.push_back(size);
        fb.push_back(size_neg);
        fb.push_back(dest);
        fb.push_back(8'($urandom_range(0, 255)));
        fb.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < size; i++)
        begin
            case (marked ? (i % 3) : $urandom_range(0, 7))
                0:       pb = start_marker;   // sync value inside the frame is plain data
                1:       pb = 8'h00;
                2:       pb = 8'hFF;
                default: pb = 8'($urandom_range(0, 255));
            endcase
            fb.push_back(pb);
        end
        fb.push_back(check[15:8]);
        fb.push_back(check[7:0]);
        for (int i = 0; i < fb.size() && i < keep; i++)
        begin
            rx_bytes_pending.push_back(fb[i]);
            frame_bytes_queued++;
        end
        frames_queued++;
    endtask

    // mostly well-formed frames, some with bad fields, a few cut short
    task automatic queue_random_frame();
        int unsigned pick;
        int unsigned size;
        int unsigned keep;
        logic [7:0]  size_neg;
        logic [7:0]  dest;
        logic [7:0]  junk;
        logic [15:0] check;
        // line noise while hunting for sync
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                junk = 8'($urandom_range(0, 255));
                if (junk == start_marker)
                    junk = ~junk;
                rx_bytes_pending.push_back(junk);
            end
        end
        pick = $urandom_range(0, 99);
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        size_neg = 8'd0 - 8'(size);
        dest = own_address;
        check = expected_check;
        keep = 1000;
        if (pick < 8)
            size_neg = corrupt(size_neg);
        else if (pick < 16)
            dest = corrupt(dest);
        else if (pick < 24)
            check[15:8] = corrupt(check[15:8]);
        else if (pick < 32)
            check[7:0] = corrupt(check[7:0]);
        else if (pick < 35)
            check = {corrupt(check[15:8]), corrupt(check[7:0])};
        else if (pick >= 95)
            keep = $urandom_range(1, size + 7);
        queue_frame(8'(size), size_neg, dest, check, keep, 1'b0);
    endtask

    // wait until the block is empty, then let the pipeline settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (rx_bytes_pending.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // new register setting and idling style, then fill with random frames
    task automatic start_phase(logic [7:0] addr, logic [7:0] sync, logic [15:0] check,
                               int unsigned target, bit bursty, stall_style_t style);
        write_reg(REG_LOCAL_ADDRESS, {8'h00, addr});
        write_reg(REG_SYNC_VALUE, {8'h00, sync});
        write_reg(REG_CHECK_WORD, check);
        settings_used++;
        sender_bursty <= bursty;
        stall_style <= style;
        stall_pattern <= 8'($urandom_range(1, 254));
        frame_bytes_queued = 0;
        while (frame_bytes_queued < target)
            queue_random_frame();
    endtask

    // test sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        sender_bursty <= 1'b1;
        stall_style <= STALL_SOME;

        // directed frames at reset settings
        rx_bytes_pending.push_back(8'hFF);      // noise before sync
        // empty payload, good check
        queue_frame(8'd0, 8'd0, own_address, expected_check, 1000, 1'b0);
        // sync and edge values inside the payload, high check byte wrong
        queue_frame(8'd2, 8'hFE, own_address, {corrupt(expected_check[15:8]),
                    expected_check[7:0]}, 1000, 1'b1);
        // addressed to another node, so ignored
        queue_frame(8'd0, 8'd0, corrupt(own_address), expected_check, 1000, 1'b0);
        wait_drained();

        // reset values written back, with a long receiver hold
        start_phase(LOCAL_ADDRESS_RESET, SYNC_VALUE_RESET, CHECK_WORD_RESET, 300, 1'b1,
                    STALL_SOME);
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        wait_drained();

        // low sync and check values, top address, plus one frame of the largest size
        start_phase(8'hFF, 8'h00, 16'h0000, 130, 1'b1, STALL_HEAVY);
        queue_frame(8'd255, 8'd1, own_address, expected_check, 1000, 1'b0);
        wait_drained();

        // high sync and check values, address zero, both sides running flat out
        start_phase(8'h00, 8'hFF, 16'hFFFF, 300, 1'b0, STALL_NONE);
        wait_drained();

        // random setting; sender pauses midway until every result is back
        start_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 300, 1'b1, STALL_SOME);
        while (rx_bytes_pending.size() > 150)
            @(posedge clk);
        sender_hold <= 1'b1;
        do
            @(posedge clk);
        while (in_valid || expected_results.size() != 0);
        sender_hold <= 1'b0;
        wait_drained();

        start_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 300, 1'b1, STALL_PATTERN);
        wait_drained();

        start_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 300, 1'b0, STALL_HEAVY);
        wait_drained();

        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d received bytes in %0d queued frames over %0d register settings",
                 bytes_accepted, frames_queued, settings_used);
        $display("results seen: %0d payload items, %0d frames accepted, %0d check failures",
                 payload_seen, accepted_seen, failed_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
